/* rtl/core/sensor_table_linearizer_top_defines.svh */
// Assertion macros for the sensor table linearizer.
// Define NO_ASSERTIONS to compile them out.
`ifndef SENSOR_TABLE_LINEARIZER_TOP_DEFINES_SVH
`define SENSOR_TABLE_LINEARIZER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define STL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define STL_ASSERT(label, prop, msg)
`define STL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/core/stl_pkg.sv */
`default_nettype none

package stl_pkg;

  // Number of sensor kinds with a table entry, and the default kind limit.
  localparam int KIND_COUNT    = 15;
  localparam int NUM_KINDS_DEF = 15;
  localparam int DIV_BITS      = 16;

  // Table sources: 0..7 are fixed tables.
  localparam logic [3:0] SRC_LINEAR = 4'd8;
  localparam logic [3:0] SRC_MV     = 4'd9;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KIND    = 3'd0;
  localparam logic [2:0] CFG_MIN_IN  = 3'd1;
  localparam logic [2:0] CFG_MAX_IN  = 3'd2;
  localparam logic [2:0] CFG_MIN_OUT = 3'd3;
  localparam logic [2:0] CFG_MAX_OUT = 3'd4;

  typedef struct packed {
    logic signed [15:0] min_in;
    logic signed [15:0] max_in;
    logic signed [15:0] min_out;
    logic signed [15:0] max_out;
  } lin_cfg_t;

  // One item in the search pipeline.
  typedef struct packed {
    logic signed [15:0] vx;
    logic [3:0]         src;
    logic [3:0]         l;
    logic [3:0]         r;
    logic               done;
    logic [3:0]         hidx;
    logic [1:0]         status;
  } srch_t;

  // Side information that travels along the divider.
  typedef struct packed {
    logic               hit;
    logic               neg;
    logic signed [15:0] base;
    logic [1:0]         status;
  } side_t;

  localparam logic [3:0] KIND_SRC [0:14] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
    SRC_LINEAR, SRC_LINEAR, SRC_LINEAR, SRC_LINEAR, SRC_MV
  };

  localparam logic [3:0] FIX_LAST [0:7] = '{
    4'd13, 4'd8, 4'd8, 4'd9, 4'd10, 4'd10, 4'd15, 4'd11
  };

  localparam logic signed [15:0] FIX_X [0:7][0:15] = '{
    '{-16'sd580, -16'sd196, 16'sd0, 16'sd526, 16'sd1022, 16'sd1188, 16'sd1466, 16'sd1964,
      16'sd2461, 16'sd2738, 16'sd2964, 16'sd3975, 16'sd4291, 16'sd4484, 16'sd0, 16'sd0},
    '{-16'sd261, -16'sd52, 16'sd0, 16'sd899, 16'sd1598, 16'sd2531, 16'sd3471, 16'sd4496,
      16'sd4751, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd385, -16'sd77, 16'sd0, 16'sd1179, 16'sd1979, 16'sd2996, 16'sd3970, 16'sd4992,
      16'sd5241, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd155, 16'sd0, 16'sd59, 16'sd299, 16'sd619, 16'sd939, 16'sd1260, 16'sd1500,
      16'sd1740, 16'sd1819, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd150, 16'sd0, 16'sd59, 16'sd299, 16'sd619, 16'sd940, 16'sd1260, 16'sd1499,
      16'sd1739, 16'sd1900, 16'sd2059, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd0, 16'sd0, 16'sd2, 16'sd63, 16'sd211, 16'sd408, 16'sd632, 16'sd812,
      16'sd1004, 16'sd1138, 16'sd1275, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd623, -16'sd618, -16'sd600, -16'sd575, -16'sd544, -16'sd507, -16'sd464, -16'sd417,
      -16'sd147, 16'sd0, 16'sd427, 16'sd875, 16'sd1036, 16'sd1313, 16'sd1842, 16'sd2086},
    '{-16'sd990, -16'sd490, 16'sd0, 16'sd480, 16'sd950, 16'sd1410, 16'sd1870, 16'sd2310,
      16'sd2750, 16'sd3180, 16'sd3590, 16'sd4010, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
  };

  localparam logic signed [15:0] FIX_Y [0:7][0:15] = '{
    '{-16'sd1300, -16'sd400, 16'sd0, 16'sd1000, 16'sd1900, 16'sd2200, 16'sd2700, 16'sd3600,
      16'sd4500, 16'sd5000, 16'sd5400, 16'sd7100, 16'sd7600, 16'sd7900, 16'sd0, 16'sd0},
    '{-16'sd1100, -16'sd200, 16'sd0, 16'sd2900, 16'sd4800, 16'sd7200, 16'sd9600, 16'sd12300,
      16'sd13000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd1100, -16'sd200, 16'sd0, 16'sd2900, 16'sd4800, 16'sd7200, 16'sd9600, 16'sd12300,
      16'sd13000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd310, 16'sd0, 16'sd930, 16'sd3720, 16'sd6920, 16'sd9830, 16'sd12540, 16'sd14520,
      16'sd16530, 16'sd17220, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd310, 16'sd0, 16'sd930, 16'sd3600, 16'sd6530, 16'sd9150, 16'sd11550, 16'sd13260,
      16'sd14960, 16'sd16110, 16'sd17280, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd310, 16'sd0, 16'sd930, 16'sd3600, 16'sd6530, 16'sd9150, 16'sd11550, 16'sd13260,
      16'sd14960, 16'sd16110, 16'sd17280, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{-16'sd2600, -16'sd2500, -16'sd2300, -16'sd2100, -16'sd1900, -16'sd1700, -16'sd1500,
      -16'sd1300, -16'sd400, 16'sd0, 16'sd1000, 16'sd1900, 16'sd2200, 16'sd2700, 16'sd3600,
      16'sd4000},
    '{-16'sd1000, -16'sd500, 16'sd0, 16'sd500, 16'sd1000, 16'sd1500, 16'sd2000, 16'sd2500,
      16'sd3000, 16'sd3500, 16'sd4000, 16'sd4500, 16'sd0, 16'sd0, 16'sd0, 16'sd0}
  };

  // Breakpoint x of a table; the register tables have three points.
  function automatic logic signed [15:0] pt_x(logic [3:0] src, logic [3:0] idx,
                                              lin_cfg_t c);
    logic signed [15:0] v;
    if (src < SRC_LINEAR) begin
      v = FIX_X[src[2:0]][idx];
    end else begin
      unique case (idx)
        4'd0:    v = c.min_in;
        4'd1:    v = '0;
        default: v = c.max_in;
      endcase
    end
    return v;
  endfunction

  // Breakpoint y of a table.
  function automatic logic signed [15:0] pt_y(logic [3:0] src, logic [3:0] idx,
                                              lin_cfg_t c);
    logic signed [15:0] v;
    if (src < SRC_LINEAR) begin
      v = FIX_Y[src[2:0]][idx];
    end else begin
      unique case (idx)
        4'd0:    v = (src == SRC_LINEAR) ? c.min_out : c.min_in;
        4'd1:    v = '0;
        default: v = (src == SRC_LINEAR) ? c.max_out : c.max_in;
      endcase
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sensor_table_linearizer_top.sv */
// Sensor table linearizer.
// Input channel: sample with in_valid / in_stall; a beat is taken at a clock
// edge with in_valid high and in_stall low. Output channel: value and status
// with out_valid / out_stall, same rule. Each sample gives exactly one result.
// The configuration port writes one register per edge with cfg_we high:
// index 0 sensor kind, 1..4 the linear table end points. Write it only while
// no beat is in flight.
// The path from an accepted input beat to out_valid runs through one input
// register, a range check, four search stages, a segment fetch, a multiply,
// sixteen divider stages (one quotient bit each) and the output register.
// One beat per cycle unless stalled; the 16-stage divider sets the depth.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle, so nothing is dropped or repeated.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none
`include "sensor_table_linearizer_top_defines.svh"

module sensor_table_linearizer_top import stl_pkg::*; #(
  parameter int NUM_KINDS = NUM_KINDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      value,
  output logic [1:0]              status,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic       adv;
  logic [3:0] sensor_kind;
  lin_cfg_t   cfg;

  // The pipeline moves unless a finished result is held by the receiver.
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_kind <= '0;
      cfg.min_in  <= -16'sd2000;
      cfg.max_in  <= 16'sd12000;
      cfg.min_out <= -16'sd2000;
      cfg.max_out <= 16'sd12000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KIND:    sensor_kind <= cfg_data[3:0];
        CFG_MIN_IN:  cfg.min_in  <= cfg_data;
        CFG_MAX_IN:  cfg.max_in  <= cfg_data;
        CFG_MIN_OUT: cfg.min_out <= cfg_data;
        CFG_MAX_OUT: cfg.max_out <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table selection for the current kind; unknown kinds use the last one.
  logic [4:0] kind_eff;
  logic [3:0] src_sel;
  logic [3:0] last_sel;

  always_comb begin
    kind_eff = {1'b0, sensor_kind};
    if (int'(kind_eff) >= NUM_KINDS) begin
      kind_eff = 5'(NUM_KINDS - 1);
    end
    if (kind_eff >= 5'(KIND_COUNT)) begin
      kind_eff = 5'(KIND_COUNT - 1);
    end
    src_sel  = KIND_SRC[kind_eff[3:0]];
    last_sel = (src_sel < SRC_LINEAR) ? FIX_LAST[src_sel[2:0]] : 4'd2;
  end

  // Input register.
  logic               v1;
  logic signed [15:0] vx1;
  logic [3:0]         src1;
  logic [3:0]         last1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vx1   <= sample;
      src1  <= src_sel;
      last1 <= last_sel;
    end
  end

  // Bracketing search.
  logic  vs;
  srch_t s;

  stl_search u_search (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v1),
    .in_vx    (vx1),
    .in_src   (src1),
    .in_last  (last1),
    .cfg      (cfg),
    .out_vld  (vs),
    .out_item (s)
  );

  // Segment fetch: offset, slope terms and the base value.
  side_t       prep_side;
  logic [15:0] prep_a;
  logic [15:0] prep_mag;
  logic [15:0] prep_dx;

  always_comb begin
    logic signed [15:0] xl;
    logic signed [15:0] xr;
    logic signed [15:0] yl;
    logic signed [15:0] yr;
    logic signed [15:0] yh;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [16:0] a;
    logic signed [16:0] mag;
    xl  = pt_x(s.src, s.l, cfg);
    xr  = pt_x(s.src, s.r, cfg);
    yl  = pt_y(s.src, s.l, cfg);
    yr  = pt_y(s.src, s.r, cfg);
    yh  = pt_y(s.src, s.hidx, cfg);
    dx  = {xr[15], xr} - {xl[15], xl};
    dy  = {yr[15], yr} - {yl[15], yl};
    a   = {s.vx[15], s.vx} - {xl[15], xl};
    mag = dy[16] ? -dy : dy;
    prep_side.hit    = s.done || (dx == '0);
    prep_side.neg    = dy[16];
    prep_side.base   = s.done ? yh : yl;
    prep_side.status = s.status;
    prep_a   = a[15:0];
    prep_mag = mag[15:0];
    prep_dx  = dx[15:0];
  end

  logic        v7;
  side_t       side7;
  logic [15:0] a7;
  logic [15:0] mag7;
  logic [15:0] dx7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side7 <= prep_side;
      a7    <= prep_a;
      mag7  <= prep_mag;
      dx7   <= prep_dx;
    end
  end

  // Numerator magnitude.
  logic        v8;
  side_t       side8;
  logic [31:0] prod8;
  logic [15:0] dx8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side8 <= side7;
      prod8 <= a7 * mag7;
      dx8   <= dx7;
    end
  end

  // Pipelined divide.
  logic        vd;
  logic [15:0] quo;
  side_t       sided;

  stl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (v8),
    .num      (prod8),
    .den      (dx8),
    .in_side  (side8),
    .out_vld  (vd),
    .quo      (quo),
    .out_side (sided)
  );

  // Sign, base add and saturation.
  logic signed [15:0] res;

  always_comb begin
    logic signed [17:0] sq;
    logic signed [17:0] sum;
    sq  = sided.neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    sum = {{2{sided.base[15]}}, sided.base} + sq;
    if (sided.hit) begin
      res = sided.base;
    end else if (sum > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      res = -16'sh8000;
    end else begin
      res = sum[15:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value  <= res;
      status <= sided.status;
    end
  end

  `STL_ASSERT(a_status_code, out_valid |-> (status == ST_OK || status == ST_UNDER || status == ST_OVER), "status code out of range")
  `STL_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a held result")
  `STL_ASSERT_NEXT(a_result_held, out_valid && out_stall, out_valid, "held result was dropped")

endmodule

`default_nettype wire

/* rtl/core/stl_search.sv */
`default_nettype none

module stl_search import stl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adv,
  input  wire logic               in_vld,
  input  wire logic signed [15:0] in_vx,
  input  wire logic [3:0]         in_src,
  input  wire logic [3:0]         in_last,
  input  wire lin_cfg_t           cfg,
  output logic                    out_vld,
  output srch_t                   out_item
);

  localparam int STEPS = 4;

  srch_t entry;
  srch_t stg [0:STEPS];
  srch_t nxt [0:STEPS-1];
  logic  vld [0:STEPS];

  // One halving step of the bracketing search.
  function automatic srch_t step(srch_t s, lin_cfg_t c);
    srch_t              o;
    logic [4:0]         sum;
    logic [3:0]         mid;
    logic signed [15:0] xm;
    o   = s;
    sum = {1'b0, s.l} + {1'b0, s.r};
    mid = sum[4:1];
    xm  = pt_x(s.src, mid, c);
    if (!s.done && ((s.r - s.l) > 4'd1)) begin
      if (s.vx > xm) begin
        o.l = mid;
      end else if (s.vx < xm) begin
        o.r = mid;
      end else begin
        o.done = 1'b1;
        o.hidx = mid;
      end
    end
    return o;
  endfunction

  // Range check against the end points; clamped items skip the search.
  always_comb begin
    logic signed [15:0] x0;
    logic signed [15:0] xn;
    x0 = pt_x(in_src, 4'd0, cfg);
    xn = pt_x(in_src, in_last, cfg);
    entry        = '0;
    entry.vx     = in_vx;
    entry.src    = in_src;
    entry.r      = in_last;
    entry.status = ST_OK;
    if (in_vx <= x0) begin
      entry.done   = 1'b1;
      entry.hidx   = 4'd0;
      entry.status = (in_vx < x0) ? ST_UNDER : ST_OK;
    end else if (in_vx > xn) begin
      entry.done   = 1'b1;
      entry.hidx   = in_last;
      entry.status = ST_OVER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= entry;
    end
  end

  // Search stages, one halving each.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    assign nxt[k] = step(stg[k], cfg);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[k+1] <= nxt[k];
      end
    end
  end

  assign out_vld  = vld[STEPS];
  assign out_item = stg[STEPS];

endmodule

`default_nettype wire

/* rtl/core/stl_div.sv */
`default_nettype none

module stl_div import stl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        adv,
  input  wire logic        in_vld,
  input  wire logic [31:0] num,
  input  wire logic [15:0] den,
  input  wire side_t       in_side,
  output logic             out_vld,
  output logic [15:0]      quo,
  output side_t            out_side
);

  // The quotient is known to fit in DIV_BITS bits, so the upper half of the
  // numerator starts as the partial remainder.
  logic [15:0] rem  [0:DIV_BITS];
  logic [15:0] lo   [0:DIV_BITS];
  logic [15:0] q    [0:DIV_BITS];
  logic [15:0] d    [0:DIV_BITS];
  side_t       sd   [0:DIV_BITS];
  logic        vld  [0:DIV_BITS];

  assign rem[0] = num[31:16];
  assign lo[0]  = num[15:0];
  assign q[0]   = '0;
  assign d[0]   = den;
  assign sd[0]  = in_side;
  assign vld[0] = in_vld;

  // Restoring division, one quotient bit per stage.
  for (genvar i = 0; i < DIV_BITS; i++) begin : g_bit
    logic [16:0] t;
    logic [16:0] diff;
    logic        ge;

    assign t    = {rem[i], lo[i][15]};
    assign diff = t - {1'b0, d[i]};
    assign ge   = (t >= {1'b0, d[i]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (adv) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i+1] <= ge ? diff[15:0] : t[15:0];
        lo[i+1]  <= {lo[i][14:0], 1'b0};
        q[i+1]   <= {q[i][14:0], ge};
        d[i+1]   <= d[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_vld  = vld[DIV_BITS];
  assign quo      = q[DIV_BITS];
  assign out_side = sd[DIV_BITS];

endmodule

`default_nettype wire
